FILE: sv/bsdc_pkg.sv
// Package for the single/double click detector.
// Holds widths, reset values, event codes and the saturating timer increment.
// No dependencies.
package bsdc_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned WinW   = 8;
  localparam int unsigned CountW = 2;

  localparam logic [WinW-1:0]   WinReset    = 8'd50;
  localparam logic [CountW-1:0] CountNone   = 2'd0;
  localparam logic [CountW-1:0] CountSingle = 2'd1;
  localparam logic [CountW-1:0] CountDouble = 2'd2;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvDouble = 2'd2
  } click_e;

  // One step handed to the core: advance strobe plus the sampled key level.
  typedef struct packed {
    logic en;
    logic key_level;
  } step_t;

  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    sat_inc = (v == {TimerW{1'b1}}) ? v : v + {{(TimerW-1){1'b0}}, 1'b1};
  endfunction

endpackage

FILE: sv/bsdc_if.sv
// Valid/ready channel interfaces for the click detector.
// Key sample channel and click event channel; no dependencies.
interface bsdc_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface bsdc_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] click_event;

  modport source (output valid, output click_event, input ready);
  modport sink   (input valid, input click_event, output ready);
endinterface

FILE: sv/bsdc_core.sv
// Click classification core: press/edge flags, press count and both timers.
// Uses bsdc_pkg.
module bsdc_core
  import bsdc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  step_t           step_i,
  input  logic [WinW-1:0] window_i,
  output click_e          event_o
);

  logic              press_seen_q, press_seen_d;
  logic              edge_counted_q, edge_counted_d;
  logic [CountW-1:0] press_count_q, press_count_d;
  logic [TimerW-1:0] window_timer_q, window_timer_d;
  logic [TimerW-1:0] hold_timer_q, hold_timer_d;

  logic              pressed;
  logic              done;
  logic [TimerW-1:0] win_ext;
  click_e            ev;

  assign win_ext = {{(TimerW-WinW){1'b0}}, window_i};

  always_comb begin
    pressed        = ~step_i.key_level;
    hold_timer_d   = pressed ? sat_inc(hold_timer_q) : '0;
    press_seen_d   = press_seen_q | pressed;
    edge_counted_d = edge_counted_q;
    press_count_d  = press_count_q;
    window_timer_d = window_timer_q;
    ev             = EvNone;
    done           = 1'b0;

    // new press counted once; second one is a double click
    if (!edge_counted_q) begin
      if (press_seen_d) begin
        press_count_d  = press_count_d + CountSingle;
        edge_counted_d = 1'b1;
      end
      if (press_count_d == CountDouble) begin
        press_count_d  = CountNone;
        window_timer_d = '0;
        ev             = EvDouble;
        done           = 1'b1;
      end
    end

    if (!done) begin
      if (!pressed) begin
        press_seen_d   = 1'b0;
        edge_counted_d = 1'b0;
      end
      if (press_count_d == CountSingle) begin
        window_timer_d = sat_inc(window_timer_d);
        if ((window_timer_d > win_ext) && (hold_timer_d < win_ext)) begin
          press_count_d  = CountNone;
          window_timer_d = '0;
          ev             = EvSingle;
        end else if (hold_timer_d > win_ext) begin
          // long hold drops the pending click
          press_count_d  = CountNone;
          window_timer_d = '0;
        end
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_seen_q   <= 1'b0;
      edge_counted_q <= 1'b0;
      press_count_q  <= CountNone;
      window_timer_q <= '0;
      hold_timer_q   <= '0;
    end else if (step_i.en) begin
      press_seen_q   <= press_seen_d;
      edge_counted_q <= edge_counted_d;
      press_count_q  <= press_count_d;
      window_timer_q <= window_timer_d;
      hold_timer_q   <= hold_timer_d;
    end
  end

  // count never rests at double; it is consumed on the same tick
  a_count_below_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_count_q != CountDouble)
    else $error("press count resting at double");

  a_double_clears_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.en && (ev == EvDouble) |=> (window_timer_q == '0) && (press_count_q == CountNone))
    else $error("double click did not clear window state");

endmodule

FILE: sv/button_single_double_click_detector_top.sv
// Top level of the single/double click detector.
// Uses bsdc_pkg, bsdc_if.sv (bsdc_key_if, bsdc_evt_if) and bsdc_core.
//
// One key sample beat is one tick. The block takes a beat every clock cycle
// and returns exactly one click event beat for each (none, single, double).
// A beat goes into an input register and is classified by the core's
// combinational logic on its way into the output register. The output and
// input registers advance together whenever the output is empty or being
// taken, so the rate is one beat per cycle; only back-pressure on the event
// channel slows it. click_window (reset 50) is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while no beat is in flight,
// as the block does not enforce it. It is both the single-click wait in ticks
// and the hold length that cancels a pending click. Timers saturate at 65535.
module button_single_double_click_detector_top
  import bsdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  bsdc_key_if.sink           key_i,
  bsdc_evt_if.source         evt_o,
  input  logic               cfg_we_i,
  input  logic [WinW-1:0]    cfg_wdata_i
);

  logic            in_v_q;
  logic            key_q;
  logic            out_v_q;
  click_e          evt_q;
  logic [WinW-1:0] win_q;
  logic            advance;
  step_t           step;
  click_e          core_ev;

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinReset;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // input stage moves into the output stage when the output slot frees up
  assign advance     = in_v_q & (~out_v_q | evt_o.ready);
  assign key_i.ready = ~in_v_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (key_i.ready) begin
      in_v_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      key_q <= key_i.key_level;
    end
  end

  assign step.en        = advance;
  assign step.key_level = key_q;

  bsdc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .window_i (win_q),
    .event_o  (core_ev)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (evt_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      evt_q <= core_ev;
    end
  end

  assign evt_o.valid       = out_v_q;
  assign evt_o.click_event = evt_q;

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_v_q)
    else $error("classified beat lost before output register");

  a_held_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !advance |=> in_v_q && $stable(key_q))
    else $error("stalled input beat dropped or changed");

endmodule
